// ===== sv/assert_macros.svh =====
// Assertion macros shared by the limiter RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WIRL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("limiter assertion failed");

// Next-cycle implication.
`define WIRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("limiter assertion failed");

`endif

// ===== sv/wirl_pkg.sv =====
// Package for the windowed invalid-request limiter.
// Command, decision and register codes, field widths and the result record.
`default_nettype none

package wirl_pkg;

    localparam int unsigned TIME_W  = 64;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned TOT_W   = 64;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 5;

    typedef enum logic [1:0] {
        CMD_CHECK    = 2'd0,
        CMD_RECORD   = 2'd1,
        CMD_SNAPSHOT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        DEC_ALLOW  = 2'd0,
        DEC_DELAY  = 2'd1,
        DEC_REJECT = 2'd2
    } t_decision;

    typedef enum logic [1:0] {
        RSN_NONE = 2'd0,
        RSN_SOFT = 2'd1,
        RSN_HARD = 2'd2
    } t_reason;

    typedef enum logic [1:0] {
        MODE_REJECT_NONCRIT = 2'd0,
        MODE_REJECT_ALL     = 2'd1,
        MODE_DELAY_ALL      = 2'd2
    } t_hard_mode;

    typedef enum logic [2:0] {
        REG_WINDOW_LEN = 3'd0,
        REG_SOFT_LIMIT = 3'd1,
        REG_HARD_LIMIT = 3'd2,
        REG_HARD_MODE  = 3'd3,
        REG_DELAY_AMT  = 3'd4
    } t_reg_idx;

    localparam logic [DATA_W-1:0] WINDOW_LEN_RST = 32'd60000;

    typedef struct packed {
        logic [1:0]        decision;
        logic [1:0]        reason;
        logic [31:0]       wait_ms;
        logic              critical_out;
        logic [TIME_W-1:0] window_start_ms;
        logic [CNT_W-1:0]  invalid_in_window;
        logic [TOT_W-1:0]  requests_total;
        logic [TOT_W-1:0]  invalid_total;
        logic [TOT_W-1:0]  delayed_total;
        logic [TOT_W-1:0]  rejected_total;
        logic              soft_exceeded;
        logic              hard_exceeded;
    } t_rsp;

endpackage

`default_nettype wire

// ===== sv/wirl_if.sv =====
// Stream interfaces of the limiter: command channel and result channel.
// Widths come from wirl_pkg.
`default_nettype none

interface wirl_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     command;
    logic [wirl_pkg::TIME_W-1:0]    now_ms;
    logic                           is_critical;
    logic                           response_invalid;

    modport source (output valid, command, now_ms, is_critical, response_invalid,
                    input ready);
    modport sink   (input valid, command, now_ms, is_critical, response_invalid,
                    output ready);
endinterface

interface wirl_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     decision;
    logic [1:0]                     reason;
    logic [31:0]                    wait_ms;
    logic                           critical_out;
    logic [wirl_pkg::TIME_W-1:0]    window_start_ms;
    logic [wirl_pkg::CNT_W-1:0]     invalid_in_window;
    logic [wirl_pkg::TOT_W-1:0]     requests_total;
    logic [wirl_pkg::TOT_W-1:0]     invalid_total;
    logic [wirl_pkg::TOT_W-1:0]     delayed_total;
    logic [wirl_pkg::TOT_W-1:0]     rejected_total;
    logic                           soft_exceeded;
    logic                           hard_exceeded;

    modport source (output valid, decision, reason, wait_ms, critical_out,
                    window_start_ms, invalid_in_window, requests_total,
                    invalid_total, delayed_total, rejected_total,
                    soft_exceeded, hard_exceeded,
                    input ready);
    modport sink   (input valid, decision, reason, wait_ms, critical_out,
                    window_start_ms, invalid_in_window, requests_total,
                    invalid_total, delayed_total, rejected_total,
                    soft_exceeded, hard_exceeded,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/windowed_invalid_request_limiter_top.sv =====
// Windowed invalid-request limiter: input register, one-pass decision logic,
// result register, APB register file. Uses wirl_pkg, wirl_if.sv, assert_macros.svh.
//
//  channel   dir   handshake              payload
//  i_req     in    valid/ready            command, now_ms, is_critical, response_invalid
//  o_rsp     out   valid/ready            decision ... hard_exceeded (one per command)
//  apb       in    psel/penable/pready    5 registers at byte address 4*index
//
// One command per cycle unless o_rsp stalls; each passes the input, then the result register.
// The window end add (64-bit saturating) and its compare set the cycle time.
// Reset is synchronous: window closed, counters zero, registers at their defaults.
// A stalled result holds the result register; the input register still takes one
// more transaction, then ready drops until the result moves on.
`default_nettype none
`include "assert_macros.svh"

module windowed_invalid_request_limiter_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    wirl_req_if.sink                            i_req,
    wirl_rsp_if.source                          o_rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wirl_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [wirl_pkg::DATA_W-1:0]    pwdata,
    output logic      [wirl_pkg::DATA_W-1:0]    prdata,
    output logic                                pready
);

    // configuration
    logic [31:0] r_window_len;
    logic [31:0] r_soft_limit;
    logic [31:0] r_hard_limit;
    logic [1:0]  r_hard_mode;
    logic [31:0] r_delay_amt;

    // limiter state
    logic                           r_open;
    logic [wirl_pkg::TIME_W-1:0]    r_begin;
    logic [wirl_pkg::CNT_W-1:0]     r_win_cnt;
    logic [wirl_pkg::TOT_W-1:0]     r_req_tot;
    logic [wirl_pkg::TOT_W-1:0]     r_inv_tot;
    logic [wirl_pkg::TOT_W-1:0]     r_dly_tot;
    logic [wirl_pkg::TOT_W-1:0]     r_rej_tot;

    // input register
    logic                           r_in_valid;
    logic [1:0]                     r_in_cmd;
    logic [wirl_pkg::TIME_W-1:0]    r_in_now;
    logic                           r_in_crit;
    logic                           r_in_inval;

    // result register
    logic                           r_out_valid;
    wirl_pkg::t_rsp                 r_out;

    logic                           w_adv;
    logic                           w_in_acc;
    logic                           w_cfg_wr;
    wirl_pkg::t_reg_idx             w_reg_idx;

    logic                           n_open;
    logic [wirl_pkg::TIME_W-1:0]    n_begin;
    logic [wirl_pkg::CNT_W-1:0]     n_win_cnt;
    logic [wirl_pkg::TOT_W-1:0]     n_req_tot;
    logic [wirl_pkg::TOT_W-1:0]     n_inv_tot;
    logic [wirl_pkg::TOT_W-1:0]     n_dly_tot;
    logic [wirl_pkg::TOT_W-1:0]     n_rej_tot;
    wirl_pkg::t_rsp                 n_out;

    logic [wirl_pkg::TIME_W:0]      w_end_sum;
    logic [wirl_pkg::TIME_W-1:0]    w_end;
    logic                           w_norm;
    logic                           w_restart;
    logic [wirl_pkg::CNT_W-1:0]     w_cnt0;
    logic                           w_hard0;
    logic                           w_soft0;

    assign w_adv    = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_in_acc = i_req.valid && i_req.ready;

    // ---------------- APB register file ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = wirl_pkg::t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= wirl_pkg::WINDOW_LEN_RST;
            r_soft_limit <= '0;
            r_hard_limit <= '1;
            r_hard_mode  <= wirl_pkg::MODE_REJECT_NONCRIT;
            r_delay_amt  <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                wirl_pkg::REG_WINDOW_LEN: r_window_len <= pwdata;
                wirl_pkg::REG_SOFT_LIMIT: r_soft_limit <= pwdata;
                wirl_pkg::REG_HARD_LIMIT: r_hard_limit <= pwdata;
                wirl_pkg::REG_HARD_MODE:  r_hard_mode  <= pwdata[1:0];
                wirl_pkg::REG_DELAY_AMT:  r_delay_amt  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            wirl_pkg::REG_WINDOW_LEN: prdata = r_window_len;
            wirl_pkg::REG_SOFT_LIMIT: prdata = r_soft_limit;
            wirl_pkg::REG_HARD_LIMIT: prdata = r_hard_limit;
            wirl_pkg::REG_HARD_MODE:  prdata = {30'd0, r_hard_mode};
            wirl_pkg::REG_DELAY_AMT:  prdata = r_delay_amt;
            default:                  prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_cmd   <= i_req.command;
            r_in_now   <= i_req.now_ms;
            r_in_crit  <= i_req.is_critical;
            r_in_inval <= i_req.response_invalid;
        end
    end

    // ---------------- decision logic ----------------
    // window end saturates at all ones
    assign w_end_sum = {1'b0, r_begin} + {{(wirl_pkg::TIME_W - 31){1'b0}}, r_window_len};
    assign w_end     = w_end_sum[wirl_pkg::TIME_W] ? '1 : w_end_sum[wirl_pkg::TIME_W-1:0];
    assign w_norm    = (r_in_cmd == wirl_pkg::CMD_CHECK) || (r_in_cmd == wirl_pkg::CMD_RECORD);
    assign w_restart = w_norm && (!r_open || (r_in_now >= w_end));
    assign w_cnt0    = w_restart ? '0 : r_win_cnt;
    assign w_hard0   = w_cnt0 >= r_hard_limit;
    assign w_soft0   = (r_soft_limit != '0) && (w_cnt0 >= r_soft_limit);

    always_comb begin
        n_open    = r_open || w_norm;
        n_begin   = w_restart ? r_in_now : r_begin;
        n_win_cnt = w_cnt0;
        n_req_tot = r_req_tot;
        n_inv_tot = r_inv_tot;
        n_dly_tot = r_dly_tot;
        n_rej_tot = r_rej_tot;

        n_out              = '0;
        n_out.decision     = wirl_pkg::DEC_ALLOW;
        n_out.reason       = wirl_pkg::RSN_NONE;

        case (r_in_cmd)
            wirl_pkg::CMD_CHECK: begin
                n_req_tot          = r_req_tot + {63'd0, (r_req_tot != '1)};
                n_out.critical_out = r_in_crit;
                if (w_hard0 && (r_hard_mode == wirl_pkg::MODE_DELAY_ALL)) begin
                    n_dly_tot      = r_dly_tot + {63'd0, (r_dly_tot != '1)};
                    n_out.decision = wirl_pkg::DEC_DELAY;
                    n_out.reason   = wirl_pkg::RSN_HARD;
                    n_out.wait_ms  = r_delay_amt;
                end else if (w_hard0 && ((r_hard_mode == wirl_pkg::MODE_REJECT_ALL)
                                         || !r_in_crit)) begin
                    n_rej_tot      = r_rej_tot + {63'd0, (r_rej_tot != '1)};
                    n_out.decision = wirl_pkg::DEC_REJECT;
                    n_out.reason   = wirl_pkg::RSN_HARD;
                end else if (w_soft0 && (r_delay_amt != '0)) begin
                    // critical requests past the hard limit reach here too unless all are rejected or delayed
                    n_dly_tot      = r_dly_tot + {63'd0, (r_dly_tot != '1)};
                    n_out.decision = wirl_pkg::DEC_DELAY;
                    n_out.reason   = wirl_pkg::RSN_SOFT;
                    n_out.wait_ms  = r_delay_amt;
                end
            end
            wirl_pkg::CMD_RECORD: begin
                if (r_in_inval) begin
                    n_win_cnt = w_cnt0 + {31'd0, (w_cnt0 != '1)};
                    n_inv_tot = r_inv_tot + {63'd0, (r_inv_tot != '1)};
                end
            end
            default: ;  // snapshot and the unused code leave state alone
        endcase

        n_out.window_start_ms   = n_open ? n_begin : r_in_now;
        n_out.invalid_in_window = n_win_cnt;
        n_out.requests_total    = n_req_tot;
        n_out.invalid_total     = n_inv_tot;
        n_out.delayed_total     = n_dly_tot;
        n_out.rejected_total    = n_rej_tot;
        n_out.soft_exceeded     = (r_soft_limit != '0) && (n_win_cnt >= r_soft_limit);
        n_out.hard_exceeded     = n_win_cnt >= r_hard_limit;
    end

    // ---------------- state and result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_begin   <= '0;
            r_win_cnt <= '0;
            r_req_tot <= '0;
            r_inv_tot <= '0;
            r_dly_tot <= '0;
            r_rej_tot <= '0;
        end else if (w_adv) begin
            r_open    <= n_open;
            r_begin   <= n_begin;
            r_win_cnt <= n_win_cnt;
            r_req_tot <= n_req_tot;
            r_inv_tot <= n_inv_tot;
            r_dly_tot <= n_dly_tot;
            r_rej_tot <= n_rej_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.decision          = r_out.decision;
    assign o_rsp.reason            = r_out.reason;
    assign o_rsp.wait_ms           = r_out.wait_ms;
    assign o_rsp.critical_out      = r_out.critical_out;
    assign o_rsp.window_start_ms   = r_out.window_start_ms;
    assign o_rsp.invalid_in_window = r_out.invalid_in_window;
    assign o_rsp.requests_total    = r_out.requests_total;
    assign o_rsp.invalid_total     = r_out.invalid_total;
    assign o_rsp.delayed_total     = r_out.delayed_total;
    assign o_rsp.rejected_total    = r_out.rejected_total;
    assign o_rsp.soft_exceeded     = r_out.soft_exceeded;
    assign o_rsp.hard_exceeded     = r_out.hard_exceeded;

    // ---------------- assertions ----------------
    `WIRL_ASSERT_NOW(a_reject_is_hard,
        r_out_valid && (r_out.decision == wirl_pkg::DEC_REJECT),
        r_out.reason == wirl_pkg::RSN_HARD)
    `WIRL_ASSERT_NOW(a_delay_only_when_delayed,
        r_out_valid && (r_out.wait_ms != '0),
        r_out.decision == wirl_pkg::DEC_DELAY)
    `WIRL_ASSERT_NOW(a_ready_when_empty,
        !r_in_valid,
        i_req.ready)
    `WIRL_ASSERT_NEXT(a_requests_monotonic,
        1'b1,
        r_req_tot >= $past(r_req_tot))

endmodule

`default_nettype wire
